FILE: rtl/lccp_pkg.sv
// ----------------------------------------------------------------------------
// lccp_pkg: shared constants and types for the coefficient compress packer
// Field widths, width mode codes, per-mode multiply constants and the word
// type held in the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lccp_pkg;

	localparam int COEFF_W = 12;
	localparam int MODE_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int Q_W     = 11;   // widest compressed value
	localparam int D_W     = 4;    // holds a bit count up to 11
	localparam int MUL_W   = 21;
	localparam int PROD_W  = 35;   // signed product plus rounding, with margin
	localparam int SHAMT_W = 5;
	localparam int PEND_W  = 7;
	localparam int PCNT_W  = 3;
	localparam int ACC_W   = 18;   // 7 pending bits plus 11 new ones
	localparam int TOT_W   = 5;

	// width_mode codes
	localparam logic [MODE_W-1:0] MODE_D1  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_D4  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_D5  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_D10 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_D11 = 3'd4;

	localparam logic [MUL_W-1:0] MUL_SMALL = 21'd315;
	localparam logic [MUL_W-1:0] MUL_LARGE = 21'd1290167;

	localparam logic [SHAMT_W-1:0] SHIFT_D1  = 5'd19;
	localparam logic [SHAMT_W-1:0] SHIFT_D4  = 5'd16;
	localparam logic [SHAMT_W-1:0] SHIFT_D5  = 5'd15;
	localparam logic [SHAMT_W-1:0] SHIFT_D10 = 5'd22;
	localparam logic [SHAMT_W-1:0] SHIFT_D11 = 5'd21;

	localparam logic signed [PROD_W-1:0] RND_D1  = 35'sd262144;   // 1 << 18
	localparam logic signed [PROD_W-1:0] RND_D4  = 35'sd32768;    // 1 << 15
	localparam logic signed [PROD_W-1:0] RND_D5  = 35'sd16384;    // 1 << 14
	localparam logic signed [PROD_W-1:0] RND_D10 = 35'sd2097152;  // 1 << 21
	localparam logic signed [PROD_W-1:0] RND_D11 = 35'sd1048576;  // 1 << 20

	localparam logic [Q_W-1:0] MASK_D1  = 11'h001;
	localparam logic [Q_W-1:0] MASK_D4  = 11'h00f;
	localparam logic [Q_W-1:0] MASK_D5  = 11'h01f;
	localparam logic [Q_W-1:0] MASK_D10 = 11'h3ff;
	localparam logic [Q_W-1:0] MASK_D11 = 11'h7ff;

	localparam logic [D_W-1:0] NBITS_D1  = 4'd1;
	localparam logic [D_W-1:0] NBITS_D4  = 4'd4;
	localparam logic [D_W-1:0] NBITS_D5  = 4'd5;
	localparam logic [D_W-1:0] NBITS_D10 = 4'd10;
	localparam logic [D_W-1:0] NBITS_D11 = 4'd11;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              last;
	} out_word_t;

endpackage

`default_nettype wire

FILE: rtl/lccp_ifs.sv
// ----------------------------------------------------------------------------
// lccp interfaces: valid/ready channels of the coefficient compress packer
// Coefficient input, packed byte output and width mode write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lccp_coeff_if;
	import lccp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COEFF_W-1:0] coeff;
	modport source (output valid, output coeff, input ready);
	modport sink   (input valid, input coeff, output ready);
endinterface

interface lccp_byte_if;
	import lccp_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packed_byte;
	logic              last;
	modport source (output valid, output packed_byte, output last, input ready);
	modport sink   (input valid, input packed_byte, input last, output ready);
endinterface

interface lccp_cfg_if;
	import lccp_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] width_mode;
	modport source (output valid, output width_mode, input ready);
	modport sink   (input valid, input width_mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/lattice_coeff_compress_pack.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack: coefficient compressor and LSB-first packer
// Usage:
//   coeffs takes one signed 12-bit coefficient per word. Each is compressed
//   to D bits (D = 1, 4, 5, 10 or 11, set by the width mode register) by a
//   constant multiply, rounding and arithmetic shift, then appended above
//   the pending bits. Every complete byte leaves on bytes, lowest first,
//   with last set on the final byte caused by that coefficient; an input
//   may cause zero, one or two bytes. Unused mode codes drop the input.
//   cfg writes the width mode (ready is always high); write it
//   only while no coefficient is in flight.
// Path: an accepted coefficient passes the input register, the compress
//   register and the byte queue before its first byte is shown on bytes.
// Throughput: one coefficient per cycle while the queue has room; the
//   multiplier register and the packer each take one per cycle. Output
//   is one byte per cycle; with D of 10 or 11 the sustained input rate is 8/D.
// A four-entry byte queue feeds bytes; when bytes stalls, the queue fills
//   and then the pipeline holds and coeffs.ready drops.
// Reset clears the mode to 1 bit, the pending bits and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_coeff_compress_pack (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lccp_coeff_if.sink   coeffs,
	lccp_byte_if.source  bytes,
	lccp_cfg_if.sink     cfg
);
	import lccp_pkg::*;

	logic [MODE_W-1:0]         mode_q;

	logic                      valid_s1;
	logic signed [COEFF_W-1:0] coeff_s1;

	logic                      valid_s2;
	logic [Q_W-1:0]            q_s2;
	logic [D_W-1:0]            nbits_s2;

	logic [PEND_W-1:0]         pend_q;
	logic [PCNT_W-1:0]         pcnt_q;

	out_word_t                 queue_q [QDEPTH];
	logic [QPTR_W-1:0]         wr_ptr_q;
	logic [QPTR_W-1:0]         rd_ptr_q;
	logic [QCNT_W-1:0]         count_q;

	logic                      adv1;
	logic                      adv2;
	logic                      room;
	logic                      pop;

	// per-mode constants
	logic [MUL_W-1:0]          mul;
	logic [SHAMT_W-1:0]        shamt;
	logic signed [PROD_W-1:0]  rnd;
	logic [Q_W-1:0]            mask;
	logic [D_W-1:0]            nbits;
	logic                      mode_ok;

	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  shifted;

	logic [ACC_W-1:0]          acc;
	logic [TOT_W-1:0]          total;
	logic [1:0]                nbytes;
	logic [PEND_W-1:0]         pend_next;
	logic [QCNT_W-1:0]         pushed;

	// mode register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_D1;
		end else if (cfg.valid) begin
			mode_q <= cfg.width_mode;
		end
	end

	// flow control
	assign room         = (count_q < QCNT_W'(QDEPTH - 1));
	assign adv2         = valid_s2 && room;
	assign adv1         = valid_s1 && (!valid_s2 || adv2);
	assign coeffs.ready = !valid_s1 || adv1;
	assign pop          = bytes.valid && bytes.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coeffs.ready) begin
			valid_s1 <= coeffs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coeffs.valid && coeffs.ready) begin
			coeff_s1 <= coeffs.coeff;
		end
	end

	always_comb begin
		mul     = MUL_SMALL;
		shamt   = SHIFT_D1;
		rnd     = RND_D1;
		mask    = MASK_D1;
		nbits   = NBITS_D1;
		mode_ok = 1'b1;
		unique case (mode_q)
			MODE_D1: begin
				mul = MUL_SMALL; shamt = SHIFT_D1; rnd = RND_D1;
				mask = MASK_D1; nbits = NBITS_D1;
			end
			MODE_D4: begin
				mul = MUL_SMALL; shamt = SHIFT_D4; rnd = RND_D4;
				mask = MASK_D4; nbits = NBITS_D4;
			end
			MODE_D5: begin
				mul = MUL_SMALL; shamt = SHIFT_D5; rnd = RND_D5;
				mask = MASK_D5; nbits = NBITS_D5;
			end
			MODE_D10: begin
				mul = MUL_LARGE; shamt = SHIFT_D10; rnd = RND_D10;
				mask = MASK_D10; nbits = NBITS_D10;
			end
			MODE_D11: begin
				mul = MUL_LARGE; shamt = SHIFT_D11; rnd = RND_D11;
				mask = MASK_D11; nbits = NBITS_D11;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
	end

	// floor shift of the rounded product; arithmetic shift gives the floor
	assign prod    = PROD_W'(coeff_s1) * PROD_W'($signed({1'b0, mul})) + rnd;
	assign shifted = prod >>> shamt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv2) begin
			valid_s2 <= valid_s1 && mode_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			q_s2     <= shifted[Q_W-1:0] & mask;
			nbits_s2 <= nbits;
		end
	end

	// bit packer
	assign acc    = ACC_W'(pend_q) | (ACC_W'(q_s2) << pcnt_q);
	assign total  = TOT_W'(pcnt_q) + TOT_W'(nbits_s2);
	assign nbytes = total[4:3];
	assign pushed = adv2 ? QCNT_W'(nbytes) : '0;

	always_comb begin
		unique case (nbytes)
			2'd0:    pend_next = acc[PEND_W-1:0];
			2'd1:    pend_next = acc[PEND_W+7:8];
			2'd2:    pend_next = PEND_W'(acc[ACC_W-1:16]);
			default: pend_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (adv2) begin
			pend_q <= pend_next;
			pcnt_q <= total[PCNT_W-1:0];
		end
	end

	// output byte queue
	always_ff @(posedge clk) begin
		if (adv2 && nbytes != 2'd0) begin
			queue_q[wr_ptr_q] <= '{packed_byte: acc[7:0], last: (nbytes == 2'd1)};
		end
		if (adv2 && nbytes == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= '{packed_byte: acc[15:8], last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pushed[QPTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + pushed - QCNT_W'(pop);
		end
	end

	assign bytes.valid       = (count_q != '0);
	assign bytes.packed_byte = queue_q[rd_ptr_q].packed_byte;
	assign bytes.last        = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

FILE: rtl/lccp_checker.sv
// ----------------------------------------------------------------------------
// lccp_checker: port-level checks for the coefficient compress packer
// Watches the byte channel and input backpressure of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lccp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lccp_pkg::BYTE_W-1:0] out_byte,
	input wire logic                        out_last
);
	import lccp_pkg::*;

	// input backpressure only comes from a filled byte queue
	a_ready_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while no byte is offered");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("byte withdrawn before it was taken");

	a_out_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("stalled byte changed");

endmodule

bind lattice_coeff_compress_pack lccp_checker u_lccp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (coeffs.ready),
	.out_valid (bytes.valid),
	.out_ready (bytes.ready),
	.out_byte  (bytes.packed_byte),
	.out_last  (bytes.last)
);

`default_nettype wire

FILE: bench/lccp_byte_checker.sv
// ----------------------------------------------------------------------------
// lccp_byte_checker: byte stream predictor and scoreboard
// Watches the coefficient, byte and width mode channels. Each accepted
// coefficient is compressed and packed by a local model, and every accepted
// byte is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module lccp_byte_checker (
	input  logic  clk,
	input  logic  arst_n,
	lccp_coeff_if coeff_bus,
	lccp_byte_if  byte_bus,
	lccp_cfg_if   mode_bus,
	output int    fail_count,
	output int    outstanding
);
	import lccp_pkg::*;

	localparam int MAX_REPORTS = 10;

	logic [MODE_W-1:0] mode_q;
	logic [6:0]        stream_bits;
	logic [2:0]        stream_cnt;
	out_word_t         due_bytes[$];
	int                errors;

	// Round c * k / 2^shift to the nearest integer, keep the low nbits.
	function automatic void round_compress(input logic [MODE_W-1:0] m,
			input logic signed [COEFF_W-1:0] c, output logic [10:0] q,
			output int nbits);
		longint k;
		longint prod;
		int     shift;
		k     = 0;
		shift = 1;
		nbits = 0;
		q     = '0;
		case (m)
			MODE_D1:  begin k = 315;     shift = 19; nbits = 1;  end
			MODE_D4:  begin k = 315;     shift = 16; nbits = 4;  end
			MODE_D5:  begin k = 315;     shift = 15; nbits = 5;  end
			MODE_D10: begin k = 1290167; shift = 22; nbits = 10; end
			MODE_D11: begin k = 1290167; shift = 21; nbits = 11; end
			default:  nbits = 0;
		endcase
		if (nbits != 0) begin
			prod = longint'(c) * k + (longint'(1) << (shift - 1));
			q = 11'((prod >>> shift) & ((longint'(1) << nbits) - 1));
		end
	endfunction

	// Append the compressed bits to the stream and queue every full byte.
	function automatic void pack_coeff(input logic signed [COEFF_W-1:0] c);
		logic [10:0] q;
		int          nbits;
		logic [17:0] acc;
		int          total;
		out_word_t   w;
		round_compress(mode_q, c, q, nbits);
		if (nbits != 0) begin
			acc   = 18'(stream_bits) | (18'(q) << stream_cnt);
			total = int'(stream_cnt) + nbits;
			while (total >= 8) begin
				w.packed_byte = acc[7:0];
				w.last        = (total < 16);
				due_bytes.push_back(w);
				acc   = acc >> 8;
				total = total - 8;
			end
			stream_bits = acc[6:0];
			stream_cnt  = 3'(total);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		if (!arst_n) begin
			mode_q      = MODE_D1;
			stream_bits = '0;
			stream_cnt  = '0;
			errors      = 0;
			due_bytes.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (mode_bus.valid && mode_bus.ready)
				mode_q = mode_bus.width_mode;
			if (byte_bus.valid && byte_bus.ready) begin
				if (due_bytes.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected byte %02h last %0b", $time,
							byte_bus.packed_byte, byte_bus.last);
					errors++;
				end else begin
					w = due_bytes.pop_front();
					if (w.packed_byte !== byte_bus.packed_byte || w.last !== byte_bus.last) begin
						if (errors < MAX_REPORTS)
							$display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
								$time, w.packed_byte, w.last, byte_bus.packed_byte,
								byte_bus.last);
						errors++;
					end
				end
			end
			if (coeff_bus.valid && coeff_bus.ready)
				pack_coeff(coeff_bus.coeff);
			fail_count  <= errors;
			outstanding <= due_bytes.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/lattice_coeff_compress_pack_tb.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack_tb: stimulus and verdict for the compress packer
// Drives directed edge coefficients in every width mode, then random phases
// of coefficients under random width modes with random idling on both
// channels, one long output stall and full drains before each mode write.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_coeff_compress_pack_tb;
	import lccp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1025;
	localparam int QUIET_TAIL  = 120;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 8;
	localparam int DIR_N       = 24;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   cycle_count = 0;
	int   fail_count;
	int   outstanding;
	bit   quiet    = 1'b0;
	bit   hold_req = 1'b0;

	logic [MODE_W-1:0] dir_mode [DIR_N] = '{
		MODE_D1, MODE_D1, MODE_D1, MODE_D1, MODE_D1, MODE_D1, MODE_D1,
		MODE_D4, MODE_D4, MODE_D4,
		MODE_D5, MODE_D5, MODE_D5,
		MODE_D10, MODE_D10, MODE_D10, MODE_D10,
		MODE_D11, MODE_D11, MODE_D11, MODE_D11, MODE_D11,
		MODE_SPARE_HI, MODE_SPARE_HI
	};
	int dir_coeff [DIR_N] = '{
		-1664, 1664, -832, 832, -2048, 2047, 0,
		2047, -1, 832,
		1664, -1664, -2048,
		-1664, 1664, 1, -1,
		-1664, 1664, -2048, 2047, 0,
		100, -100
	};

	lccp_coeff_if coeff_bus ();
	lccp_byte_if  byte_bus ();
	lccp_cfg_if   mode_bus ();

	lattice_coeff_compress_pack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.coeffs (coeff_bus),
		.bytes  (byte_bus),
		.cfg    (mode_bus)
	);

	lccp_byte_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.coeff_bus   (coeff_bus),
		.byte_bus    (byte_bus),
		.mode_bus    (mode_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL lattice_coeff_compress_pack");
			$finish;
		end
	end

	task automatic send_coeff(input int c);
		coeff_bus.valid <= 1'b1;
		coeff_bus.coeff <= COEFF_W'(c);
		do @(posedge clk); while (!coeff_bus.ready);
	endtask

	task automatic idle_coeff(input int n);
		coeff_bus.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold input until every predicted byte is out, then let the pipe settle.
	task automatic wait_drained();
		coeff_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		wait_drained();
		mode_bus.valid      <= 1'b1;
		mode_bus.width_mode <= m;
		do @(posedge clk); while (!mode_bus.ready);
		mode_bus.valid <= 1'b0;
	endtask

	// Output side: random ready bursts, one long hold on request.
	initial begin
		byte_bus.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				byte_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				byte_bus.ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end else begin
				byte_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin
		int                sent;
		int                phase;
		int                n;
		int                c;
		int                r;
		logic [MODE_W-1:0] m;
		coeff_bus.valid     <= 1'b0;
		coeff_bus.coeff     <= '0;
		mode_bus.valid      <= 1'b0;
		mode_bus.width_mode <= MODE_D1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Edge values per mode; mode changes leave bits pending.
		for (int i = 0; i < DIR_N; i++) begin
			if (i == 0 || dir_mode[i] != dir_mode[i-1])
				write_mode(dir_mode[i]);
			send_coeff(dir_coeff[i]);
		end

		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			r = $urandom_range(0, 15);
			if (r < 14)
				m = MODE_W'(r % 5);
			else
				m = MODE_W'(int'(MODE_SPARE_LO) + $urandom_range(0, 2));
			if (phase == 2)
				m = MODE_D11;
			write_mode(m);
			if (phase == 2)
				hold_req = 1'b1;
			n = (m > MODE_D11) ? $urandom_range(5, 15) : $urandom_range(20, 100);
			for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
				if (sent >= RAND_ITEMS - QUIET_TAIL)
					quiet = 1'b1;
				if ($urandom_range(0, 4) != 0)
					c = int'($urandom_range(0, 3328)) - 1664;
				else
					c = int'($urandom_range(0, 4095));
				send_coeff(c);
				if (m <= MODE_D11)
					sent++;
				if (!quiet && $urandom_range(0, 3) == 0)
					idle_coeff($urandom_range(1, 18));
				if (!quiet && (phase == 4 && k == n / 2))
					wait_drained();
			end
			phase++;
		end

		quiet = 1'b1;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS lattice_coeff_compress_pack");
		else
			$display("FAIL lattice_coeff_compress_pack");
		$finish;
	end

endmodule

`default_nettype wire
